>>> rtl/core/polygon_point_inside_test_assert.svh
// Assertion macros shared by the point-in-polygon RTL.
// Depends on nothing; included by the modules that carry assertions.
`ifndef POLYGON_POINT_INSIDE_TEST_ASSERT_SVH
`define POLYGON_POINT_INSIDE_TEST_ASSERT_SVH

`ifndef ASSERT_OFF

// The consequent must hold in the same cycle as the antecedent.
`define PIP_ASSERT_IMP(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("same-cycle implication violated");

// The consequent must hold in the cycle after the antecedent.
`define PIP_ASSERT_NXT(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle implication violated");

`else

`define PIP_ASSERT_IMP(name, clk, rst_n, ante, cons)
`define PIP_ASSERT_NXT(name, clk, rst_n, ante, cons)

`endif

`endif

>>> rtl/core/pip_pkg.sv
// Shared types and constants for the point-in-polygon block.
// Depends on nothing; used by every module of the block.
package pip_pkg;

    localparam int COORD_W          = 32;
    localparam int MAX_VERTICES_DEF = 64;
    localparam int QUEUE_DEPTH      = 4;
    localparam int QPTR_W           = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W           = $clog2(QUEUE_DEPTH + 1);

    // Command codes on the input port.
    localparam logic CMD_VERTEX = 1'b0;
    localparam logic CMD_QUERY  = 1'b1;

    // Operation of a classified word.
    typedef enum logic [1:0] {
        OP_VERTEX,
        OP_NEW_POLY,
        OP_QUERY
    } op_t;

    typedef struct packed {
        op_t                        op;
        logic signed [COORD_W-1:0]  x;
        logic signed [COORD_W-1:0]  y;
    } item_t;

    typedef struct packed {
        logic                       in_poly;
        logic signed [COORD_W-1:0]  cx;
        logic signed [COORD_W-1:0]  cy;
        logic                       empty;
        logic                       ovf;
    } result_t;

endpackage

>>> rtl/core/pip_front.sv
// Front end: accepts input words, classifies them and queues them for the back end.
// Depends on pip_pkg and the assertion macro header.
`include "polygon_point_inside_test_assert.svh"

module pip_front
    import pip_pkg::*;
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       push,
    output logic                       full,
    input  logic                       cmd,
    input  logic signed [COORD_W-1:0]  coord_x,
    input  logic signed [COORD_W-1:0]  coord_y,
    input  logic                       start_polygon,
    output logic                       q_valid,
    output item_t                      q_item,
    input  logic                       q_pop
);

    item_t              slot_mem [QUEUE_DEPTH];
    item_t              in_item;
    logic [QPTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0]  count_reg, count_next;
    logic               wr_en;

    // Classify the incoming word; the start flag only matters on a vertex.
    always_comb
    begin
        in_item.x = coord_x;
        in_item.y = coord_y;
        if (cmd == CMD_QUERY)
        begin
            in_item.op = OP_QUERY;
        end
        else if (start_polygon)
        begin
            in_item.op = OP_NEW_POLY;
        end
        else
        begin
            in_item.op = OP_VERTEX;
        end
    end

    assign full    = (count_reg == QCNT_W'(QUEUE_DEPTH));
    assign wr_en   = push && !full;
    assign q_valid = (count_reg != '0);
    assign q_item  = slot_mem[rd_ptr_reg];

    // Queue storage.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            slot_mem[wr_ptr_reg] <= in_item;
        end
    end

    // Pointer and fill count update.
    always_comb
    begin
        wr_ptr_next = wr_en ? wr_ptr_reg + QPTR_W'(1) : wr_ptr_reg;
        rd_ptr_next = q_pop ? rd_ptr_reg + QPTR_W'(1) : rd_ptr_reg;
        count_next  = count_reg;
        if (wr_en && !q_pop)
        begin
            count_next = count_reg + QCNT_W'(1);
        end
        else if (!wr_en && q_pop)
        begin
            count_next = count_reg - QCNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // The fill count never passes the depth, and the back end never pops an empty queue.
    `PIP_ASSERT_IMP(a_q_bound, clk, rst_n, 1'b1, count_reg <= QCNT_W'(QUEUE_DEPTH))
    `PIP_ASSERT_IMP(a_q_pop_nonempty, clk, rst_n, q_pop, count_reg != '0)

endmodule

>>> rtl/core/pip_walker.sv
// Back end: vertex store, bounding box registers and the pipelined edge walker.
// Depends on pip_pkg and the assertion macro header.
`include "polygon_point_inside_test_assert.svh"

module pip_walker
    import pip_pkg::*;
#(
    parameter int MAX_VERTICES = MAX_VERTICES_DEF
)
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     q_valid,
    input  item_t    q_item,
    output logic     q_pop,
    input  logic     res_ready,
    output logic     res_valid,
    output result_t  res_data
);

    localparam int IDX_W = $clog2(MAX_VERTICES);
    localparam int CNT_W = $clog2(MAX_VERTICES + 1);
    localparam int DW    = COORD_W + 1;
    localparam int PW    = 2 * DW;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_ISSUE,
        ST_DRAIN,
        ST_DONE
    } state_t;

    function automatic logic signed [DW-1:0] sext(input logic signed [COORD_W-1:0] v);
        return {v[COORD_W-1], v};
    endfunction

    // Vertex store, one write and one registered read per cycle.
    logic signed [COORD_W-1:0] vert_x_mem [MAX_VERTICES];
    logic signed [COORD_W-1:0] vert_y_mem [MAX_VERTICES];
    logic                      mem_we;
    logic [IDX_W-1:0]          mem_waddr;
    logic [IDX_W-1:0]          mem_raddr;
    logic signed [COORD_W-1:0] rd_x_reg, rd_y_reg;

    // Control state.
    state_t                    state_reg, state_next;
    logic [CNT_W-1:0]          vcount_reg, vcount_next;
    logic                      dropped_reg, dropped_next;
    logic signed [COORD_W-1:0] min_x_reg, min_x_next, max_x_reg, max_x_next;
    logic signed [COORD_W-1:0] min_y_reg, min_y_next, max_y_reg, max_y_next;
    logic [CNT_W-1:0]          iss_idx_reg, iss_idx_next;
    logic                      tok_valid_reg, tok_valid_next;
    logic                      tok_first_reg, tok_first_next;
    logic                      tok_close_reg, tok_close_next;
    logic                      b_valid_reg, b_valid_next;
    logic                      c_valid_reg, c_valid_next;
    logic                      parity_reg, parity_next;

    // Datapath registers.
    logic signed [COORD_W-1:0] px_reg, py_reg;
    logic signed [COORD_W-1:0] prev_x_reg, prev_y_reg, first_x_reg, first_y_reg;
    logic                      b_cond_reg, b_cond_next, b_vert_reg, b_vert_next;
    logic signed [DW-1:0]      b_dx1_reg, b_dx1_next, b_dy_reg, b_dy_next;
    logic signed [DW-1:0]      b_dy1_reg, b_dy1_next, b_dxe_reg, b_dxe_next;
    logic                      c_cond_reg, c_vert_reg, c_dypos_reg;
    logic signed [PW-1:0]      c_p1_reg, c_p1_next, c_p2_reg, c_p2_next;

    // Helpers.
    logic                      load_query;
    logic                      new_poly;
    logic [CNT_W-1:0]          eff_count;
    logic signed [COORD_W-1:0] ax, ay, bx, by, lo_y, hi_y, hi_x;
    logic                      edge_valid;
    logic                      hit;
    logic signed [DW-1:0]      sum_x, sum_y;

    assign sum_x = sext(min_x_reg) + sext(max_x_reg);
    assign sum_y = sext(min_y_reg) + sext(max_y_reg);
    assign mem_raddr = iss_idx_reg[IDX_W-1:0];

    // Stage A: form the edge from the previous vertex and the one just read.
    always_comb
    begin
        ax   = prev_x_reg;
        ay   = prev_y_reg;
        bx   = tok_close_reg ? first_x_reg : rd_x_reg;
        by   = tok_close_reg ? first_y_reg : rd_y_reg;
        lo_y = (ay < by) ? ay : by;
        hi_y = (ay < by) ? by : ay;
        hi_x = (ax < bx) ? bx : ax;
        edge_valid  = tok_valid_reg && !tok_first_reg;
        b_cond_next = edge_valid && (py_reg > lo_y) && (py_reg <= hi_y) && (px_reg <= hi_x);
        b_vert_next = (ax == bx);
        b_dx1_next  = sext(px_reg) - sext(ax);
        b_dy_next   = sext(by) - sext(ay);
        b_dy1_next  = sext(py_reg) - sext(ay);
        b_dxe_next  = sext(bx) - sext(ax);
    end

    // Stage B: the two cross products.
    assign c_p1_next = b_dx1_reg * b_dy_reg;
    assign c_p2_next = b_dy1_reg * b_dxe_reg;

    // Stage C: the sign-corrected compare decides whether the ray crosses the edge.
    assign hit = c_vert_reg ||
                 (c_dypos_reg ? (c_p1_reg <= c_p2_reg) : (c_p1_reg >= c_p2_reg));

    // Sequencer: loads vertices, issues edge reads and delivers results.
    always_comb
    begin
        state_next     = state_reg;
        vcount_next    = vcount_reg;
        dropped_next   = dropped_reg;
        min_x_next     = min_x_reg;
        max_x_next     = max_x_reg;
        min_y_next     = min_y_reg;
        max_y_next     = max_y_reg;
        iss_idx_next   = iss_idx_reg;
        tok_valid_next = 1'b0;
        tok_first_next = 1'b0;
        tok_close_next = 1'b0;
        b_valid_next   = edge_valid;
        c_valid_next   = b_valid_reg;
        parity_next    = parity_reg;
        q_pop          = 1'b0;
        mem_we         = 1'b0;
        load_query     = 1'b0;
        new_poly       = (q_item.op == OP_NEW_POLY);
        eff_count      = new_poly ? '0 : vcount_reg;
        mem_waddr      = eff_count[IDX_W-1:0];
        res_valid      = 1'b0;
        res_data       = '0;

        case (state_reg)
            ST_IDLE:
            begin
                if (q_valid)
                begin
                    case (q_item.op)
                        OP_VERTEX, OP_NEW_POLY:
                        begin
                            q_pop = 1'b1;
                            if (eff_count == CNT_W'(MAX_VERTICES))
                            begin
                                dropped_next = 1'b1;
                            end
                            else
                            begin
                                mem_we       = 1'b1;
                                vcount_next  = eff_count + CNT_W'(1);
                                dropped_next = new_poly ? 1'b0 : dropped_reg;
                                if (eff_count == '0)
                                begin
                                    min_x_next = q_item.x;
                                    max_x_next = q_item.x;
                                    min_y_next = q_item.y;
                                    max_y_next = q_item.y;
                                end
                                else
                                begin
                                    if (q_item.x < min_x_reg) min_x_next = q_item.x;
                                    if (q_item.x > max_x_reg) max_x_next = q_item.x;
                                    if (q_item.y < min_y_reg) min_y_next = q_item.y;
                                    if (q_item.y > max_y_reg) max_y_next = q_item.y;
                                end
                            end
                        end
                        OP_QUERY:
                        begin
                            if (vcount_reg == '0)
                            begin
                                // An empty polygon answers without a walk, once the result register is ready.
                                if (res_ready)
                                begin
                                    q_pop          = 1'b1;
                                    res_valid      = 1'b1;
                                    res_data.empty = 1'b1;
                                    res_data.ovf   = dropped_reg;
                                end
                            end
                            else
                            begin
                                q_pop        = 1'b1;
                                load_query   = 1'b1;
                                iss_idx_next = '0;
                                parity_next  = 1'b0;
                                state_next   = ST_ISSUE;
                            end
                        end
                        default:
                        begin
                            q_pop = 1'b1;
                        end
                    endcase
                end
            end
            ST_ISSUE:
            begin
                tok_valid_next = 1'b1;
                if (iss_idx_reg < vcount_reg)
                begin
                    tok_first_next = (iss_idx_reg == '0);
                    iss_idx_next   = iss_idx_reg + CNT_W'(1);
                end
                else
                begin
                    // Closing edge from the last vertex back to the first.
                    tok_close_next = 1'b1;
                    state_next     = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                if (!tok_valid_reg && !b_valid_reg && !c_valid_reg)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (res_ready)
                begin
                    res_valid        = 1'b1;
                    res_data.in_poly = parity_reg;
                    res_data.cx      = sum_x[DW-1:1];
                    res_data.cy      = sum_y[DW-1:1];
                    res_data.empty   = 1'b0;
                    res_data.ovf     = dropped_reg;
                    state_next       = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        if (c_valid_reg && c_cond_reg && hit)
        begin
            parity_next = !parity_reg;
        end
    end

    // Vertex store.
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            vert_x_mem[mem_waddr] <= q_item.x;
            vert_y_mem[mem_waddr] <= q_item.y;
        end
        rd_x_reg <= vert_x_mem[mem_raddr];
        rd_y_reg <= vert_y_mem[mem_raddr];
    end

    // State and control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            vcount_reg    <= '0;
            dropped_reg   <= 1'b0;
            min_x_reg     <= '0;
            max_x_reg     <= '0;
            min_y_reg     <= '0;
            max_y_reg     <= '0;
            iss_idx_reg   <= '0;
            tok_valid_reg <= 1'b0;
            tok_first_reg <= 1'b0;
            tok_close_reg <= 1'b0;
            b_valid_reg   <= 1'b0;
            c_valid_reg   <= 1'b0;
            parity_reg    <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            vcount_reg    <= vcount_next;
            dropped_reg   <= dropped_next;
            min_x_reg     <= min_x_next;
            max_x_reg     <= max_x_next;
            min_y_reg     <= min_y_next;
            max_y_reg     <= max_y_next;
            iss_idx_reg   <= iss_idx_next;
            tok_valid_reg <= tok_valid_next;
            tok_first_reg <= tok_first_next;
            tok_close_reg <= tok_close_next;
            b_valid_reg   <= b_valid_next;
            c_valid_reg   <= c_valid_next;
            parity_reg    <= parity_next;
        end
    end

    // Edge pipeline payload.
    always_ff @(posedge clk)
    begin
        if (load_query)
        begin
            px_reg <= q_item.x;
            py_reg <= q_item.y;
        end
        if (tok_valid_reg && tok_first_reg)
        begin
            first_x_reg <= rd_x_reg;
            first_y_reg <= rd_y_reg;
        end
        if (tok_valid_reg && !tok_close_reg)
        begin
            prev_x_reg <= rd_x_reg;
            prev_y_reg <= rd_y_reg;
        end
        b_cond_reg  <= b_cond_next;
        b_vert_reg  <= b_vert_next;
        b_dx1_reg   <= b_dx1_next;
        b_dy_reg    <= b_dy_next;
        b_dy1_reg   <= b_dy1_next;
        b_dxe_reg   <= b_dxe_next;
        c_cond_reg  <= b_cond_reg;
        c_vert_reg  <= b_vert_reg;
        c_dypos_reg <= (b_dy_reg > DW'(0));
        c_p1_reg    <= c_p1_next;
        c_p2_reg    <= c_p2_next;
    end

    // Edge work only runs during a walk, and results leave only from the right states.
    `PIP_ASSERT_IMP(a_pipe_in_walk, clk, rst_n, tok_valid_reg || b_valid_reg || c_valid_reg, state_reg == ST_ISSUE || state_reg == ST_DRAIN)
    `PIP_ASSERT_IMP(a_count_bound, clk, rst_n, 1'b1, vcount_reg <= CNT_W'(MAX_VERTICES))
    `PIP_ASSERT_IMP(a_result_source, clk, rst_n, res_valid, state_reg == ST_DONE || (state_reg == ST_IDLE && vcount_reg == '0))
    `PIP_ASSERT_NXT(a_query_starts_walk, clk, rst_n, load_query, state_reg == ST_ISSUE && iss_idx_reg == '0 && !parity_reg)

endmodule

>>> rtl/core/polygon_point_inside_test.sv
// Point-in-polygon block, top level: front queue, back-end walker and result register.
// Depends on pip_pkg, pip_front and pip_walker.
//
// The back end takes vertex words one per cycle while it is idle. A query walks every stored
// edge through the stage A, B and C edge pipeline, fed by one vertex-store read per cycle;
// a query on an empty polygon is answered without a walk. A four-word input queue and a
// one-word result register let the input side keep pushing while a finished result waits
// to be popped. No clearing pass is needed after reset.
module polygon_point_inside_test
    import pip_pkg::*;
#(
    parameter int MAX_VERTICES = MAX_VERTICES_DEF
)
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       push,
    output logic                       full,
    input  logic                       cmd,
    input  logic signed [COORD_W-1:0]  coord_x,
    input  logic signed [COORD_W-1:0]  coord_y,
    input  logic                       start_polygon,
    output logic                       empty,
    input  logic                       pop,
    output logic                       inside_res,
    output logic signed [COORD_W-1:0]  center_x,
    output logic signed [COORD_W-1:0]  center_y,
    output logic                       empty_res,
    output logic                       overflowed
);

    logic     q_valid;
    item_t    q_item;
    logic     q_pop;
    logic     res_ready;
    logic     res_valid;
    result_t  res_data;
    logic     out_valid_reg, out_valid_next;
    result_t  out_data_reg;

    pip_front u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .push          (push),
        .full          (full),
        .cmd           (cmd),
        .coord_x       (coord_x),
        .coord_y       (coord_y),
        .start_polygon (start_polygon),
        .q_valid       (q_valid),
        .q_item        (q_item),
        .q_pop         (q_pop)
    );

    pip_walker #(
        .MAX_VERTICES (MAX_VERTICES)
    ) u_walker (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_valid   (q_valid),
        .q_item    (q_item),
        .q_pop     (q_pop),
        .res_ready (res_ready),
        .res_valid (res_valid),
        .res_data  (res_data)
    );

    // One-word result register; it can take a new word in the cycle it is popped.
    assign res_ready = !out_valid_reg || pop;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (res_valid)
        begin
            out_valid_next = 1'b1;
        end
        else if (pop)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_valid)
        begin
            out_data_reg <= res_data;
        end
    end

    assign empty      = !out_valid_reg;
    assign inside_res = out_data_reg.in_poly;
    assign center_x   = out_data_reg.cx;
    assign center_y   = out_data_reg.cy;
    assign empty_res  = out_data_reg.empty;
    assign overflowed = out_data_reg.ovf;

endmodule
